// ===== rtl/sdik_pkg.sv =====
// ----------------------------------------------------------------------------
// Swerve drive kinematics package
// Shared types, register indexes and the arctangent table.
// ----------------------------------------------------------------------------
package sdik_pkg;

  localparam int unsigned NumWheels = 3;
  localparam int unsigned AccW      = 36;  // contact velocity, Q.26 with growth
  localparam int unsigned MulW      = 32;

  typedef enum logic [2:0] {
    RegFrontX = 3'd0,
    RegFrontY = 3'd1,
    RegLeftX  = 3'd2,
    RegLeftY  = 3'd3,
    RegRightX = 3'd4,
    RegRightY = 3'd5,
    RegInvRad = 3'd6,
    RegThresh = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StMulA,
    StMulB,
    StCordic,
    StMag,
    StSpeed,
    StNext,
    StDone
  } state_e;

  // Bit-serial multiplier request/status.
  typedef struct packed {
    logic start;
  } mul_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // Arctangent table, one turn equals 2^32.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    begin
      case (idx)
        5'd0:  r = 32'd536870912;
        5'd1:  r = 32'd316933406;
        5'd2:  r = 32'd167458907;
        5'd3:  r = 32'd85004756;
        5'd4:  r = 32'd42667331;
        5'd5:  r = 32'd21354465;
        5'd6:  r = 32'd10679838;
        5'd7:  r = 32'd5340245;
        5'd8:  r = 32'd2670163;
        5'd9:  r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/sdik_serial_mul.sv =====
// ----------------------------------------------------------------------------
// Bit-serial unsigned multiplier
// Shift-and-add multiply, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module sdik_serial_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sdik_pkg::mul_ctrl_t               ctrl_i,
  input  logic [sdik_pkg::MulW-1:0]         a_i,
  input  logic [sdik_pkg::MulW-1:0]         b_i,
  output sdik_pkg::mul_stat_t               stat_o,
  output logic [2*sdik_pkg::MulW-1:0]       prod_o
);
  import sdik_pkg::*;

  logic [2*MulW-1:0] acc_q, acc_d;
  logic [2*MulW-1:0] mcand_q, mcand_d;
  logic [MulW-1:0]   mplier_q, mplier_d;
  logic [5:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;

  // One multiplier bit is consumed per cycle.
  always_comb begin
    acc_d = acc_q; mcand_d = mcand_q; mplier_d = mplier_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (ctrl_i.start) begin
      acc_d = '0; mcand_d = {{MulW{1'b0}}, a_i}; mplier_d = b_i;
      cnt_d = 6'(MulW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (mplier_q[0]) acc_d = acc_q + mcand_q;
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; mcand_q <= mcand_d; mplier_q <= mplier_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;
endmodule

// ===== rtl/swerve_drive_inverse_kinematics.sv =====
// ----------------------------------------------------------------------------
// Swerve drive inverse kinematics
// Steer angle and wheel speed for three steerable wheels.
// ----------------------------------------------------------------------------
// One command is processed at a time, and the three wheels are handled in turn.
// Each wheel takes two bit-serial products for w*y and w*x, CORDIC_STAGES
// CORDIC vectoring iterations at one per cycle, a gain-correction product,
// a speed product and a step in StNext to move to the next wheel. Most of the
// processing time is spent in the shared bit-serial multiplier. The result
// register holds until transferred, and the next command is accepted in the
// cycle after the result has been taken.
module swerve_drive_inverse_kinematics #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [15:0] vel_x_i,
  input  logic signed [15:0] vel_y_i,
  input  logic signed [15:0] yaw_rate_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] steer_angle_a_o,
  output logic signed [15:0] steer_angle_b_o,
  output logic signed [15:0] steer_angle_c_o,
  output logic [23:0] wheel_speed_a_o,
  output logic [23:0] wheel_speed_b_o,
  output logic [23:0] wheel_speed_c_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import sdik_pkg::*;

  localparam int unsigned StW = $clog2(CORDIC_STAGES + 1);
  localparam logic [31:0] InvGain = 32'h9B74EDA8;

  // Configuration registers.
  logic [15:0] pos_x_q [NumWheels];
  logic [15:0] pos_y_q [NumWheels];
  logic [15:0] inv_rad_q, thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q[0] <= 16'd4096;  pos_y_q[0] <= 16'd0;
      pos_x_q[1] <= 16'hF800;  pos_y_q[1] <= 16'd3547;
      pos_x_q[2] <= 16'hF800;  pos_y_q[2] <= 16'hF225;
      inv_rad_q  <= 16'd2560;  thresh_q   <= 16'd0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegFrontX: pos_x_q[0] <= cfg_data_i;
        RegFrontY: pos_y_q[0] <= cfg_data_i;
        RegLeftX:  pos_x_q[1] <= cfg_data_i;
        RegLeftY:  pos_y_q[1] <= cfg_data_i;
        RegRightX: pos_x_q[2] <= cfg_data_i;
        RegRightY: pos_y_q[2] <= cfg_data_i;
        RegInvRad: inv_rad_q  <= cfg_data_i;
        RegThresh: thresh_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control and datapath registers.
  state_e state_q, state_d;
  logic [1:0] wheel_q, wheel_d;
  logic [StW-1:0] iter_q, iter_d;
  logic signed [15:0] vx_q, vy_q, w_q;
  logic signed [AccW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [31:0] ang_q, ang_d;
  logic [39:0] mag_q, mag_d;
  logic [15:0] held_q [NumWheels];
  logic [15:0] ang_out_q [NumWheels];
  logic [23:0] spd_out_q [NumWheels];
  logic held_we, out_we;
  logic [15:0] ang_new, ang_wr;
  logic [23:0] spd_wr;

  // Shared multiplier, signed operands handled by magnitude and sign.
  mul_ctrl_t mul_ctrl;
  mul_stat_t mul_stat;
  logic [MulW-1:0] mul_a, mul_b;
  logic [2*MulW-1:0] mul_p;
  logic mul_neg;

  sdik_serial_mul u_mul (
    .clk_i, .rst_ni, .ctrl_i(mul_ctrl), .a_i(mul_a), .b_i(mul_b),
    .stat_o(mul_stat), .prod_o(mul_p)
  );

  logic signed [15:0] py_sel, px_sel, w_cur;
  logic [15:0] w_abs, p_abs, p_nxt;
  logic signed [AccW-1:0] prod_s, dx, dy, base_x, base_y;
  logic [4:0] iter5;
  logic [39:0] thr_ext;

  assign py_sel = signed'(pos_y_q[wheel_q]);
  assign px_sel = signed'(pos_x_q[wheel_q]);
  // The first product starts in the accepting cycle, before the command is registered.
  assign w_cur  = (state_q == StIdle) ? yaw_rate_i : w_q;
  assign w_abs  = w_cur[15] ? 16'(-w_cur) : w_cur;
  assign prod_s = mul_neg ? -signed'(AccW'(mul_p)) : signed'(AccW'(mul_p));
  assign base_x = AccW'(vx_q) <<< 14;
  assign base_y = AccW'(vy_q) <<< 14;
  assign dx = cy_q >>> iter_q;
  assign dy = cx_q >>> iter_q;
  assign iter5 = 5'(iter_q);
  assign ang_new = 16'((ang_q + 32'h8000) >> 16);
  assign thr_ext = {20'd0, thresh_q, 4'd0};

  // Sign of the product that finishes in the current state.
  always_comb begin
    mul_neg = 1'b0;
    case (state_q)
      StMulA: mul_neg = w_q[15] ^ py_sel[15];
      StMulB: mul_neg = w_q[15] ^ px_sel[15];
      default: ;
    endcase
  end

  // Sequencer: products, CORDIC iterations, magnitude and speed.
  always_comb begin
    state_d = state_q; wheel_d = wheel_q; iter_d = iter_q;
    cx_d = cx_q; cy_d = cy_q; ang_d = ang_q; mag_d = mag_q;
    mul_ctrl.start = 1'b0; mul_a = {16'd0, w_abs}; mul_b = '0;
    held_we = 1'b0; out_we = 1'b0; ang_wr = held_q[wheel_q]; spd_wr = '0;
    in_ready_o = 1'b0;
    p_nxt = '0; p_abs = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = StMulA; wheel_d = '0; mul_ctrl.start = 1'b1;
        end
      end
      StMulA: begin
        if (mul_stat.done) begin
          cx_d = base_x - prod_s;
          state_d = StMulB; mul_ctrl.start = 1'b1;
        end
      end
      StMulB: begin
        if (mul_stat.done) begin
          cy_d = base_y + prod_s;
          ang_d = '0;
          if (cx_q[AccW-1]) begin
            cx_d = -cx_q; cy_d = -(base_y + prod_s); ang_d = 32'h80000000;
          end
          iter_d = '0; state_d = StCordic;
        end
      end
      StCordic: begin
        if (!cy_q[AccW-1]) begin
          cx_d = cx_q + dx; cy_d = cy_q - dy; ang_d = ang_q + atan_turn(iter5);
        end else begin
          cx_d = cx_q - dx; cy_d = cy_q + dy; ang_d = ang_q - atan_turn(iter5);
        end
        iter_d = iter_q + 1'b1;
        if (iter_q == StW'(CORDIC_STAGES - 1)) begin
          state_d = StMag;
          mul_ctrl.start = 1'b1;
        end
        mul_a = cx_d[AccW-1] ? '0 : 32'(cx_d[AccW-2:10]);
        mul_b = InvGain;
      end
      StMag: begin
        if (mul_stat.done) begin
          mag_d = 40'(mul_p >> 32);
          state_d = StSpeed;
          mul_ctrl.start = 1'b1;
        end
        mul_a = mag_d[31:0];
        mul_b = {16'd0, inv_rad_q};
      end
      StSpeed: begin
        if (mul_stat.done) begin
          out_we = 1'b1;
          if (mag_q <= thr_ext) begin
            ang_wr = held_q[wheel_q]; spd_wr = '0;
          end else begin
            held_we = 1'b1; ang_wr = ang_new;
            spd_wr = (mul_p[63:36] != '0) ? 24'hFFFFFF : mul_p[35:12];
          end
          state_d = StNext;
        end
      end
      StNext: begin
        if (wheel_q == 2'(NumWheels - 1)) begin
          state_d = StDone;
        end else begin
          wheel_d = wheel_q + 2'd1; state_d = StMulA; mul_ctrl.start = 1'b1;
        end
      end
      StDone: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    // A position product takes the position of the wheel and state it starts for.
    if (state_d == StMulA || state_d == StMulB) begin
      p_nxt = (state_d == StMulB) ? pos_x_q[wheel_d] : pos_y_q[wheel_d];
      p_abs = p_nxt[15] ? 16'(-p_nxt) : p_nxt;
      mul_b = {16'd0, p_abs};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; wheel_q <= '0; iter_q <= '0;
      for (int i = 0; i < NumWheels; i++) held_q[i] <= '0;
    end else begin
      state_q <= state_d; wheel_q <= wheel_d; iter_q <= iter_d;
      if (held_we) held_q[wheel_q] <= ang_new;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d; cy_q <= cy_d; ang_q <= ang_d; mag_q <= mag_d;
    if (in_ready_o && in_valid_i) begin
      vx_q <= vel_x_i; vy_q <= vel_y_i; w_q <= yaw_rate_i;
    end
    if (out_we) begin
      ang_out_q[wheel_q] <= ang_wr; spd_out_q[wheel_q] <= spd_wr;
    end
  end

  assign out_valid_o     = (state_q == StDone);
  assign steer_angle_a_o = ang_out_q[0];
  assign steer_angle_b_o = ang_out_q[1];
  assign steer_angle_c_o = ang_out_q[2];
  assign wheel_speed_a_o = spd_out_q[0];
  assign wheel_speed_b_o = spd_out_q[1];
  assign wheel_speed_c_o = spd_out_q[2];
endmodule

// ===== rtl/sdik_checker.sv =====
// ----------------------------------------------------------------------------
// Swerve drive kinematics port checker
// Port-level checks on the handshakes, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sdik_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [23:0] wheel_speed_a_o
);
  // A result that is offered stays offered until transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  // Wheel speed A holds while the result is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(wheel_speed_a_o))
    else $error("result changed while stalled");

  // No command is taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while result pending");

  // An accepted command yields neither a result nor input ready in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o && !in_ready_o)
    else $error("command finished too early");
endmodule

bind swerve_drive_inverse_kinematics sdik_checker u_sdik_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .wheel_speed_a_o
);
